// ===== design/dwmf_pkg.sv =====
// Shared constants and types of the distinct-window marker finder.
`default_nettype none

package dwmf_pkg;

   localparam int unsigned POSITION_BITS_DEFAULT = 16;
   localparam int unsigned SYMBOL_BITS           = 8;
   localparam int unsigned WINDOW_BITS           = 7;
   localparam int unsigned MARKER_BITS           = 16;

   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = WINDOW_BITS'(14);

   // A window of W bytes needs the W-1 bytes before the newest one.
   localparam int unsigned HIST_DEPTH = (2 ** WINDOW_BITS) - 2;

   typedef struct packed {
      logic                   valid;
      logic                   killed;   // a newer copy of this byte exists
      logic [SYMBOL_BITS-1:0] symbol;
   } cell_type;

   typedef struct packed {
      logic advance;
      logic flush;
   } cell_ctl_type;

   typedef struct packed {
      logic                   found;
      logic [MARKER_BITS-1:0] marker_end;
   } rsp_type;

endpackage

`default_nettype wire

// ===== design/dwmf_cell.sv =====
// One history cell: holds one earlier byte of the line and marks it once repeated.
`default_nettype none

module dwmf_cell #(
   parameter int unsigned AGE = 1
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire dwmf_pkg::cell_ctl_type           ctl,
   input  wire logic [dwmf_pkg::SYMBOL_BITS-1:0] symbol,
   input  wire logic [dwmf_pkg::WINDOW_BITS-1:0] window,
   input  wire dwmf_pkg::cell_type               prev,
   output      dwmf_pkg::cell_type               pass,
   output      logic                             breaks
);
   import dwmf_pkg::*;

   localparam logic [WINDOW_BITS-1:0] AgeCode = WINDOW_BITS'(AGE);

   cell_type state_ff;
   cell_type state_in;
   logic     match;

   assign match = state_ff.valid && (state_ff.symbol == symbol);

   always_comb begin
      pass.valid  = state_ff.valid;
      pass.killed = state_ff.killed | match;
      pass.symbol = state_ff.symbol;
   end

   // A repeated byte younger than the window breaks the run.
   assign breaks = pass.valid && pass.killed && (AgeCode < window);

   always_comb begin
      state_in = state_ff;
      if (ctl.flush) begin
         state_in.valid  = 1'b0;
         state_in.killed = 1'b0;
      end else if (ctl.advance) begin
         state_in = prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.valid <= 1'b0;
      end else begin
         state_ff.valid <= state_in.valid;
      end
      state_ff.killed <= state_in.killed;
      state_ff.symbol <= state_in.symbol;
   end

endmodule

`default_nettype wire

// ===== design/dwmf_out_buf.sv =====
// Two-entry result queue: output register plus skid register.
`default_nettype none

module dwmf_out_buf (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire dwmf_pkg::rsp_type push_data,
   output      logic              full,
   output      logic              out_valid,
   output      dwmf_pkg::rsp_type out_data,
   input  wire logic              out_ready
);
   import dwmf_pkg::*;

   logic    head_valid_ff, head_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type head_ff, head_in;
   rsp_type skid_ff, skid_in;
   logic    pop;

   assign pop       = head_valid_ff && out_ready;
   assign full      = skid_valid_ff;
   assign out_valid = head_valid_ff;
   assign out_data  = head_ff;

   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            head_in = push_data;
         end else begin
            head_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!head_valid_ff) begin
            head_in       = push_data;
            head_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

// ===== design/distinct_window_marker_finder.sv =====
// Top level of the distinct-window marker finder.
`default_nettype none

// Streams the bytes of a line, one request per byte with tlast on the final
// byte, and reports the first run of window_length bytes that are all
// distinct. Exactly one response comes per line: found=1 with the byte count
// through the marker end, or found=0 with 0 when the line ends without a
// marker. Bytes after a marker are consumed and dropped. A byte is taken in
// every cycle while the result queue has room; its response, if any, is
// registered into that queue. Throughput is set by one pass over the history
// chain per byte: every cell compares its stored byte with the incoming one
// in the same cycle and the run check is an OR over the cells. A two-entry
// result queue lets bytes keep flowing while a response waits; tready drops
// only while both entries are full. Write window_length only while idle.
// Positions saturate at 2^POSITION_BITS-1; once a line passes that point no
// marker is reported for it.
module distinct_window_marker_finder
   #(
   parameter int unsigned POSITION_BITS = dwmf_pkg::POSITION_BITS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // req_tdata: [7:0] symbol
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   input  wire logic [7:0]                       req_tdata,
   input  wire logic                             req_tlast,
   // rsp_tdata: [15:0] marker_end
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   output      logic [15:0]                      rsp_tdata,
   // rsp_tuser: [0] found
   output      logic                             rsp_tuser,
   input  wire logic                             csr_we,
   input  wire logic [dwmf_pkg::WINDOW_BITS-1:0] csr_wdata
);
   import dwmf_pkg::*;

   localparam logic [POSITION_BITS-1:0] PosMax = {POSITION_BITS{1'b1}};

   // Configuration
   logic [WINDOW_BITS-1:0] window_ff;

   // Line state
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic                     over_ff, over_in;  // a byte at the saturated position was taken
   logic                     done_ff, done_in;  // marker already reported

   logic                     accept;
   logic                     work;
   logic [SYMBOL_BITS-1:0]   symbol;
   logic [POSITION_BITS-1:0] pos_inc;
   logic                     len_ok;
   logic                     any_break;
   logic                     hit;
   logic [MARKER_BITS+POSITION_BITS-1:0] end_wide;

   cell_ctl_type               ctl;
   cell_type                   head;
   cell_type                   link [HIST_DEPTH];
   logic [HIST_DEPTH-1:0]      breaks;

   logic    rsp_push;
   rsp_type rsp_in;
   rsp_type rsp_out;
   logic    queue_full;

   assign symbol     = req_tdata[SYMBOL_BITS-1:0];
   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign work       = accept && !done_ff;

   // Hold the marker length.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else if (csr_we) begin
         window_ff <= csr_wdata;
      end
   end

   // Advance the history chain on every counted byte; flush it at line end.
   assign ctl.advance = work;
   assign ctl.flush   = accept && req_tlast;

   always_comb begin
      head.valid  = 1'b1;
      head.killed = 1'b0;
      head.symbol = symbol;
   end

   for (genvar i = 0; i < HIST_DEPTH; i++) begin : g_cell
      dwmf_cell #(
         .AGE (i + 1)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl    (ctl),
         .symbol (symbol),
         .window (window_ff),
         .prev   ((i == 0) ? head : link[(i == 0) ? 0 : i - 1]),
         .pass   (link[i]),
         .breaks (breaks[i])
      );
   end

   assign any_break = |breaks;

   // The run can only reach the window once enough bytes of the line exist.
   assign len_ok = ({1'b0, pos_ff} + 1'b1) >= (POSITION_BITS + 1)'(window_ff);

   assign pos_inc = (pos_ff == PosMax) ? pos_ff : pos_ff + 1'b1;
   assign hit     = work && !over_ff && len_ok && !any_break;

   assign end_wide = {MARKER_BITS'(0), pos_inc};

   // Report a marker, or a miss on the last byte of a line.
   assign rsp_push = hit || (work && req_tlast);
   always_comb begin
      rsp_in.found      = hit;
      rsp_in.marker_end = hit ? end_wide[MARKER_BITS-1:0] : '0;
   end

   always_comb begin
      pos_in  = pos_ff;
      over_in = over_ff;
      done_in = done_ff;
      if (accept && req_tlast) begin
         pos_in  = '0;
         over_in = 1'b0;
         done_in = 1'b0;
      end else if (work) begin
         pos_in  = pos_inc;
         over_in = over_ff || (pos_ff == PosMax);
         done_in = hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         over_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         over_ff <= over_in;
         done_ff <= done_in;
      end
   end

   dwmf_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in),
      .full      (queue_full),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_out),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = rsp_out.marker_end;
   assign rsp_tuser = rsp_out.found;

endmodule

`default_nettype wire

// ===== test/tb_distinct_window_marker_finder.sv =====
// Self-checking testbench for the distinct-window marker finder.
`timescale 1ns / 100ps

module tb_distinct_window_marker_finder;
   import dwmf_pkg::*;

   localparam int POS_LIMIT    = (1 << POSITION_BITS_DEFAULT) - 1;
   localparam int SYMBOL_COUNT = 1 << SYMBOL_BITS;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_BYTES = 1200;
   // Slack after the last owed response, for the block's result queue.
   localparam int DRAIN_CYCLES = 8;
   localparam int REPORT_LIMIT = 10;
   localparam int SCRIPT_ROWS  = 26;

   typedef enum bit {ROW_BYTE, ROW_WINDOW} row_kind_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_ONE_IN_FOUR,
      READY_LONG_STALL
   } ready_mode_type;

   // One step of the directed script: either a byte or a window_length write.
   // Where typed is set, the row carries the response the byte must cause.
   typedef struct {
      row_kind_type     kind;
      logic [7:0]       value;
      bit               last;
      bit               typed;
      logic             found;
      logic [15:0]      marker_end;
   } script_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = '0;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [15:0]            rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_we = 1'b0;
   logic [WINDOW_BITS-1:0] csr_wdata = '0;

   // Shadow copy of the block's line state, advanced on every accepted request.
   logic [WINDOW_BITS-1:0] window_length;
   int                     seen_at [SYMBOL_COUNT];
   bit                     seen [SYMBOL_COUNT];
   int                     run_from;
   int                     next_pos;
   bit                     marker_taken;

   // Responses still owed by the block, oldest first.
   rsp_type                pending_reports [$];

   script_row_type         script [SCRIPT_ROWS];

   int                     cycle_count = 0;
   int                     failures = 0;
   int                     bytes_sent = 0;
   int                     lines_sent = 0;
   int                     reports_checked = 0;
   int                     markers_seen = 0;
   int                     misses_seen = 0;
   int                     windows_used = 0;
   int                     burst_left = 0;
   ready_mode_type         ready_mode = READY_ALWAYS;
   int                     ready_left = 0;

   distinct_window_marker_finder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Stop a hung run.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d responses still owed", cycle_count,
               pending_reports.size());
      $display("simulation failed");
      $finish;
   end

   // Positions stop at the top of their range instead of wrapping.
   function automatic int sat_next(input int value);
      return (value >= POS_LIMIT) ? POS_LIMIT : value + 1;
   endfunction

   task automatic clear_line_state();
      foreach (seen[i]) begin
         seen[i]    = 1'b0;
         seen_at[i] = 0;
      end
      run_from     = 0;
      next_pos     = 0;
      marker_taken = 1'b0;
   endtask

   // Advance the marker search by one byte and say whether it owes a response.
   task automatic search_byte(input logic [7:0] sym, input bit last,
                              output bit produced, output rsp_type rsp);
      int pos;
      int run_len;
      produced = 1'b0;
      rsp      = '0;
      if (!marker_taken) begin
         pos = next_pos;
         // A repeat inside the current run pushes the run start past its older copy.
         if (seen[sym] && seen_at[sym] >= run_from)
            run_from = sat_next(seen_at[sym]);
         seen_at[sym] = pos;
         seen[sym]    = 1'b1;
         next_pos     = sat_next(pos);
         run_len      = (pos >= run_from) ? pos - run_from + 1 : 0;
         if (run_len >= int'(window_length)) begin
            marker_taken   = 1'b1;
            produced       = 1'b1;
            rsp.found      = 1'b1;
            rsp.marker_end = 16'(sat_next(pos));
         end else if (last) begin
            produced = 1'b1;
         end
      end
      // Clear the line after its last byte, whether or not anything was reported.
      if (last)
         clear_line_state();
   endtask

   // Offer one byte; called and returning at a falling edge. Between bursts,
   // tvalid is often dropped for a random gap so gaps land on every phase of the work.
   task automatic send_byte(input logic [7:0] sym, input bit last,
                            input bit typed, input rsp_type typed_rsp);
      int      gap;
      bit      produced;
      rsp_type predicted;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      if (burst_left > 0)
         burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= sym;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      search_byte(sym, last, produced, predicted);
      if (typed)
         pending_reports = {pending_reports, typed_rsp};
      else if (produced)
         pending_reports = {pending_reports, predicted};
      bytes_sent++;
      if (last)
         lines_sent++;
      @(negedge clock);
   endtask

   // Hold off the sender until every owed response has come and the block
   // has had time to finish with any trailing dropped bytes.
   task automatic settle_idle();
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_window(input logic [WINDOW_BITS-1:0] value);
      settle_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      window_length = value;
      windows_used++;
   endtask

   // Receiver: switch between randomly chosen readiness patterns.
   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         ready_left = 64;
      end
      ready_left--;
      case (ready_mode)
         READY_ALWAYS:      rsp_tready <= 1'b1;
         READY_COIN:        rsp_tready <= 1'($urandom_range(0, 1));
         READY_ONE_IN_FOUR: rsp_tready <= (ready_left % 4 == 0);
         default:           rsp_tready <= (ready_left % 12) < 2;
      endcase
   end

   // Compare every accepted response with the oldest owed one.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.found      = rsp_tuser;
         got.marker_end = rsp_tdata;
         reports_checked++;
         if (got.found)
            markers_seen++;
         else
            misses_seen++;
         if (pending_reports.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("unexpected response found=%0d marker_end=%0d at cycle %0d",
                        got.found, got.marker_end, cycle_count);
         end else begin
            want = pending_reports.pop_front();
            if (got.found !== want.found || got.marker_end !== want.marker_end) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("mismatch at cycle %0d: expected found=%0d marker_end=%0d, %s",
                           cycle_count, want.found, want.marker_end,
                           $sformatf("got found=%0d marker_end=%0d",
                                     got.found, got.marker_end));
            end
         end
      end
   end

   initial begin
      script_row_type row;
      rsp_type        typed_rsp;
      logic [7:0]     sym;
      int             w;
      int             style;
      int             alphabet;
      int             base;
      int             line_len;
      int             directed_bytes;

      // Extremes of the byte, windows 0 to 3, 63 and 64, and the named special cases:
      // a line with no marker, window zero, marker on the last byte, window
      // longer than the line, dropped bytes after a marker.
      script = '{
         '{ROW_BYTE,   8'h00, 1'b0, 1'b0, 1'b0, 16'd0},
         '{ROW_BYTE,   8'hFF, 1'b0, 1'b0, 1'b0, 16'd0},
         '{ROW_BYTE,   8'h00, 1'b1, 1'b1, 1'b0, 16'd0},
         '{ROW_WINDOW, 8'd0,  1'b0, 1'b0, 1'b0, 16'd0},
         '{ROW_BYTE,   8'hA5, 1'b0, 1'b1, 1'b1, 16'd1},
         '{ROW_BYTE,   8'h5A, 1'b1, 1'b0, 1'b0, 16'd0},
         '{ROW_WINDOW, 8'd1,  1'b0, 1'b0, 1'b0, 16'd0},
         '{ROW_BYTE,   8'h3C, 1'b1, 1'b1, 1'b1, 16'd1},
         '{ROW_WINDOW, 8'd64, 1'b0, 1'b0, 1'b0, 16'd0},
         '{ROW_BYTE,   8'h11, 1'b0, 1'b0, 1'b0, 16'd0},
         '{ROW_BYTE,   8'h22, 1'b0, 1'b0, 1'b0, 16'd0},
         '{ROW_BYTE,   8'h33, 1'b1, 1'b1, 1'b0, 16'd0},
         '{ROW_WINDOW, 8'd3,  1'b0, 1'b0, 1'b0, 16'd0},
         '{ROW_BYTE,   8'h01, 1'b0, 1'b0, 1'b0, 16'd0},
         '{ROW_BYTE,   8'h02, 1'b0, 1'b0, 1'b0, 16'd0},
         '{ROW_BYTE,   8'h01, 1'b0, 1'b0, 1'b0, 16'd0},
         '{ROW_BYTE,   8'h03, 1'b0, 1'b0, 1'b0, 16'd0},
         '{ROW_BYTE,   8'h04, 1'b1, 1'b0, 1'b0, 16'd0},
         '{ROW_WINDOW, 8'd2,  1'b0, 1'b0, 1'b0, 16'd0},
         '{ROW_BYTE,   8'h80, 1'b0, 1'b0, 1'b0, 16'd0},
         '{ROW_BYTE,   8'h80, 1'b0, 1'b0, 1'b0, 16'd0},
         '{ROW_BYTE,   8'h80, 1'b0, 1'b0, 1'b0, 16'd0},
         '{ROW_BYTE,   8'h7F, 1'b1, 1'b0, 1'b0, 16'd0},
         '{ROW_WINDOW, 8'd63, 1'b0, 1'b0, 1'b0, 16'd0},
         '{ROW_BYTE,   8'h55, 1'b0, 1'b0, 1'b0, 16'd0},
         '{ROW_BYTE,   8'hAA, 1'b1, 1'b1, 1'b0, 16'd0}
      };

      window_length = WINDOW_RESET;
      clear_line_state();
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (script[i]) begin
         row = script[i];
         if (row.kind == ROW_WINDOW) begin
            set_window(row.value[WINDOW_BITS-1:0]);
         end else begin
            typed_rsp.found      = row.found;
            typed_rsp.marker_end = row.marker_end;
            send_byte(row.value, row.last, row.typed, typed_rsp);
         end
      end
      directed_bytes = bytes_sent;

      // Random phases: pick a window, then send a handful of lines. Most lines
      // draw from an alphabet close to the window size so markers are found
      // at varied depths; the rest are plain noise or all-distinct lines too
      // short to hold a marker.
      while (bytes_sent - directed_bytes < RANDOM_BYTES) begin
         case ($urandom_range(0, 7))
            0:       w = 1;
            1:       w = 64;
            2:       w = $urandom_range(0, 4);
            default: w = $urandom_range(1, 64);
         endcase
         set_window(WINDOW_BITS'(w));
         repeat ($urandom_range(3, 8)) begin
            style = $urandom_range(0, 9);
            base  = $urandom_range(0, 255);
            case (style)
               0: begin
                  alphabet = SYMBOL_COUNT;
                  line_len = $urandom_range(1, 40);
               end
               1: begin
                  alphabet = 0;
                  line_len = (w > 1) ? $urandom_range(1, w - 1) : 1;
               end
               default: begin
                  alphabet = w + int'($urandom_range(0, 6)) - 2;
                  if (alphabet < 1)
                     alphabet = 1;
                  line_len = $urandom_range(1, 2 * w + 8);
               end
            endcase
            for (int k = 0; k < line_len; k++) begin
               if (alphabet == 0)
                  sym = 8'(base + k);
               else
                  sym = 8'(base + int'($urandom_range(0, alphabet - 1)));
               send_byte(sym, k == line_len - 1, 1'b0, '0);
            end
         end
      end

      settle_idle();
      if (pending_reports.size() != 0)
         failures++;

      $display("Sent %0d bytes in %0d lines over %0d window settings with bursty input",
               bytes_sent, lines_sent, windows_used);
      $display("and a stalling receiver; checked %0d responses (%0d markers, %0d misses).",
               reports_checked, markers_seen, misses_seen);
      if (failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
